/* rtl/bis_pkg.sv */
`timescale 1ns / 1ps

package bis_pkg;

    // Set geometry.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the ports.
    localparam int OP_W     = 2;
    localparam int ID_W     = 32;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_FIND = 2'd0,
        OP_ADD  = 2'd1,
        OP_TAKE = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ID_W-1:0]  wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [ID_W-1:0]    taken_id;
        logic [COUNT_W-1:0] count;
    } res_t;

    // Low bits of an index or count, as the result fields carry them.
    function automatic logic [POS_W-1:0] to_pos(input logic [31:0] v);
        return v[POS_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] to_count(input logic [31:0] v);
        return v[COUNT_W-1:0];
    endfunction

endpackage

/* rtl/bis_if.sv */
`timescale 1ns / 1ps

interface bis_req_if;
    logic                      valid;
    logic                      ready;
    logic [bis_pkg::OP_W-1:0]  opcode;
    logic [bis_pkg::ID_W-1:0]  id_value;

    modport source (output valid, output opcode, output id_value, input ready);
    modport sink   (input valid, input opcode, input id_value, output ready);
endinterface

interface bis_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bis_pkg::STAT_W-1:0]  status;
    logic [bis_pkg::POS_W-1:0]   position;
    logic [bis_pkg::ID_W-1:0]    taken_id;
    logic [bis_pkg::COUNT_W-1:0] count;

    modport source (output valid, output status, output position, output taken_id,
                    output count, input ready);
    modport sink   (input valid, input status, input position, input taken_id,
                    input count, output ready);
endinterface

/* rtl/bis_ram.sv */
`timescale 1ns / 1ps

module bis_ram (
    input  logic                     clk,
    input  bis_pkg::ram_req_t        req,
    output logic [bis_pkg::ID_W-1:0] rdata
);
    import bis_pkg::*;

    logic [ID_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

/* rtl/bis_ctrl.sv */
`timescale 1ns / 1ps

module bis_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    bis_req_if.sink                  request,
    output bis_pkg::ram_req_t        ram_req,
    input  logic [bis_pkg::ID_W-1:0] ram_rdata,
    input  logic                     res_free,
    output logic                     res_load,
    output bis_pkg::res_t            res
);
    import bis_pkg::*;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    status_t            status_reg, status_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ID_W-1:0]    taken_reg, taken_next;

    logic accept;
    logic scan_hit;
    logic scan_miss;
    logic shift_end;
    logic set_full;

    assign accept    = request.valid && request.ready;
    assign scan_hit  = cmp_valid_reg && (ram_rdata == id_reg);
    assign scan_miss = !cmp_valid_reg && (ptr_reg == count_reg);
    assign shift_end = !wr_pend_reg && (ptr_reg == count_reg);
    assign set_full  = (count_reg == CNT_W'(CAPACITY));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = (op_t'(op_reg) == OP_TAKE) ? S_SHIFT : S_DONE;
                end
                else if (scan_miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        op_next        = op_reg;
        id_next        = id_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        wr_pend_next   = 1'b0;
        wr_idx_next    = wr_idx_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        taken_next     = taken_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = wr_idx_reg;
        ram_req.wdata  = ram_rdata;
        ram_req.raddr  = ptr_reg[IDX_W-1:0];
        request.ready  = 1'b0;
        res_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    op_next     = request.opcode;
                    id_next     = request.id_value;
                    ptr_next    = '0;
                    status_next = ST_NOT_FOUND;
                    pos_next    = '0;
                    taken_next  = '0;
                end
            end
            S_SCAN:
            begin
                // One read is issued per cycle; its data is compared in the next cycle.
                if (ptr_reg != count_reg)
                begin
                    ptr_next       = ptr_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = ptr_reg[IDX_W-1:0];
                end
                if (scan_hit)
                begin
                    cmp_valid_next = 1'b0;
                    case (op_t'(op_reg))
                        OP_FIND, OP_ADD:
                        begin
                            status_next = ST_OK;
                            pos_next    = to_pos(32'(cmp_idx_reg));
                        end
                        OP_TAKE:
                        begin
                            status_next = ST_OK;
                            pos_next    = to_pos(32'(cmp_idx_reg));
                            taken_next  = id_reg;
                            ptr_next    = CNT_W'(cmp_idx_reg) + CNT_W'(1);
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
                else if (scan_miss)
                begin
                    if (op_t'(op_reg) == OP_ADD)
                    begin
                        if (set_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = count_reg[IDX_W-1:0];
                            ram_req.wdata = id_reg;
                            status_next   = ST_OK;
                            pos_next      = to_pos(32'(count_reg));
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                // Read entry i+1 now, write it into entry i next cycle.
                if (ptr_reg != count_reg)
                begin
                    ptr_next     = ptr_reg + CNT_W'(1);
                    wr_pend_next = 1'b1;
                    wr_idx_next  = IDX_W'(ptr_reg - CNT_W'(1));
                end
                if (wr_pend_reg)
                begin
                    ram_req.we = 1'b1;
                end
                if (shift_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_DONE:
            begin
                res_load = res_free;
            end
            default:
            begin
            end
        endcase

        res.status   = status_reg;
        res.position = pos_reg;
        res.taken_id = taken_reg;
        res.count    = to_count(32'(count_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        cmp_idx_reg <= cmp_idx_next;
        wr_idx_reg  <= wr_idx_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        taken_reg   <= taken_next;
    end

endmodule

/* rtl/bounded_id_set.sv */
`timescale 1ns / 1ps

// Bounded, insertion-ordered set of up to CAPACITY distinct 32-bit identifiers,
// kept in a single-port-write, single-port-read RAM with a registered read
// port. Each request word (find, add or take) yields exactly one response
// word with a status, the position of the identifier, the removed identifier
// for a take, and the count after the operation. The set handles one request
// at a time and walks the RAM one entry per cycle through its read port:
// a find or add is accepted, scanned until a hit or the end of the set and
// then posted as a response; a take that hits also moves the later entries
// down one place before its response is posted. No clearing pass runs after
// reset: only entries below the count are ever compared or moved. A new
// request is accepted while the previous response word still waits in the
// output register.

module bounded_id_set (
    input  logic     clk,
    input  logic     rst_n,
    bis_req_if.sink  request,
    bis_rsp_if.source response
);
    import bis_pkg::*;

    ram_req_t        ram_req;
    logic [ID_W-1:0] ram_rdata;
    logic            res_free;
    logic            res_load;
    res_t            res;

    logic            out_valid_reg, out_valid_next;
    res_t            out_reg, out_next;

    bis_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    bis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_free  (res_free),
        .res_load  (res_load),
        .res       (res)
    );

    // The output register takes a new word when it is empty or being drained.
    assign res_free = !out_valid_reg || response.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign response.valid    = out_valid_reg;
    assign response.status   = out_reg.status;
    assign response.position = out_reg.position;
    assign response.taken_id = out_reg.taken_id;
    assign response.count    = out_reg.count;

endmodule

/* sim/tb_bounded_id_set.sv */
`timescale 1ns / 1ps

// Self-checking bench for bounded_id_set. Request words (find, add, take and
// the unused opcode) go in through the request channel and every response
// word is checked field by field against a behavioral copy of the set kept
// in the scoreboard below. The sender works in bursts with gaps, and the
// receiver stalls on a pattern of its own, so that gaps land on every phase
// of the scan and the shift.
module tb_bounded_id_set;

    import bis_pkg::*;

    // The opcode that the package leaves unnamed. The block must ignore it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1800;
    localparam int MIX_WORDS    = 120;
    localparam int LONG_HOLD    = 300;
    // Worst case for one word: a full scan plus a full shift, with a margin.
    localparam int TAIL_CYCLES  = 2 * CAPACITY + 20;
    localparam int TIMEOUT_NS   = 4000000;

    typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_kind_t;
    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // The scoreboard holds its own copy of the set, in insertion order, and
    // the queue of response words still owed by the block.
    class set_scoreboard;
        logic [ID_W-1:0] members[$];
        res_t            owed_words[$];
        int unsigned     mismatches   = 0;
        int unsigned     words_noted  = 0;
        int unsigned     ok_words     = 0;
        int unsigned     missed_words = 0;
        int unsigned     full_words   = 0;
        int unsigned     unused_words = 0;
        int unsigned     peak_count   = 0;

        // Index of id in the set, or -1 when it is absent.
        function int locate(input logic [ID_W-1:0] id);
            foreach (members[i])
                if (members[i] == id)
                    return i;
            return -1;
        endfunction

        function logic [ID_W-1:0] random_member();
            return members[$urandom_range(0, members.size() - 1)];
        endfunction

        // Called for every accepted request word: applies it to the set and
        // queues the response word it must produce.
        function void note_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
            res_t exp;
            int   hit;
            hit          = locate(id);
            exp.status   = ST_NOT_FOUND;
            exp.position = '0;
            exp.taken_id = '0;
            case (op)
                OP_FIND:
                    if (hit >= 0)
                    begin
                        exp.status   = ST_OK;
                        exp.position = POS_W'(hit);
                    end
                OP_ADD:
                    if (hit >= 0)
                    begin
                        exp.status   = ST_OK;
                        exp.position = POS_W'(hit);
                    end
                    else if (members.size() >= CAPACITY)
                    begin
                        exp.status = ST_FULL;
                    end
                    else
                    begin
                        exp.status   = ST_OK;
                        exp.position = POS_W'(members.size());
                        members.push_back(id);
                    end
                OP_TAKE:
                    if (hit >= 0)
                    begin
                        exp.status   = ST_OK;
                        exp.position = POS_W'(hit);
                        exp.taken_id = members[hit];
                        members.delete(hit);
                    end
                default:
                    unused_words++;
            endcase
            exp.count = COUNT_W'(members.size());
            if (members.size() > peak_count)
                peak_count = members.size();
            words_noted++;
            owed_words.push_back(exp);
        endfunction

        // Called for every accepted response word.
        function void check_response(input res_t got);
            res_t exp;
            if (owed_words.size() == 0)
            begin
                $error("response word with none expected: status %0d position %0d taken %h count %0d",
                       got.status, got.position, got.taken_id, got.count);
                mismatches++;
                return;
            end
            exp = owed_words.pop_front();
            case (exp.status)
                ST_OK:   ok_words++;
                ST_FULL: full_words++;
                default: missed_words++;
            endcase
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.position !== exp.position)
            begin
                $error("position: expected %0d, got %0d", exp.position, got.position);
                mismatches++;
            end
            if (got.taken_id !== exp.taken_id)
            begin
                $error("taken_id: expected %h, got %h", exp.taken_id, got.taken_id);
                mismatches++;
            end
            if (got.count !== exp.count)
            begin
                $error("count: expected %0d, got %0d", exp.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bis_req_if req_ch ();
    bis_rsp_if rsp_ch ();

    bounded_id_set dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    set_scoreboard sb = new();

    // Words left in the current sender burst. Zero means valid is low.
    int unsigned burst_left    = 0;
    // The main process asks for a long receiver hold-off by bumping
    // hold_requests; the receiver serves it by counting cycles on its own.
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[bounded_id_set] ERROR");
        $finish;
    end

    // Offers one request word and returns at the edge that accepts it. A new
    // burst starts after a gap, so valid is never lowered and raised again
    // within one time step. Within a burst valid stays high from one word to
    // the next.
    task automatic offer_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            // One burst in five is long, which gives stretches with no idling.
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(40, 150);
            else
                burst_left = $urandom_range(1, 12);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.id_value <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, id);
        burst_left--;
        if (burst_left == 0)
            req_ch.valid <= 1'b0;
    endtask

    // Drops valid right after an accepted word, unless the burst already did.
    task automatic end_burst();
        if (burst_left != 0)
        begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic wait_for_results();
        while (sb.owed_words.size() != 0)
            @(posedge clk);
    endtask

    // Receiver. It checks every accepted response word and then decides ready
    // for the next cycle, either from a long hold-off or from a randomly
    // chosen stall mode.
    initial
    begin
        res_t        got;
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned rx_phase;
        mode_left = 0;
        hold_left = 0;
        rx_phase  = 0;
        rx_mode   = RX_STEADY;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status   = status_t'(rsp_ch.status);
                got.position = rsp_ch.position;
                got.taken_id = rsp_ch.taken_id;
                got.count    = rsp_ch.count;
                sb.check_response(got);
            end
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            rx_phase++;
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (rx_mode)
                    RX_STEADY: rsp_ch.ready <= 1'b1;
                    RX_COIN:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ch.ready <= ((rx_phase % 7) >= 3);
                endcase
            end
        end
    end

    // Main sequence: reset, a short directed part, then random phases.
    initial
    begin
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        phase_kind_t     kind;
        int              random_words;
        int              phase_no;
        int              steps;
        int              tail_left;
        int              pick;
        bit              phase_done;

        req_ch.valid    <= 1'b0;
        req_ch.opcode   <= OP_FIND;
        req_ch.id_value <= '0;
        rst_n           <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. On the empty set: a missed find, a missed take and
        // the unused opcode. Then the extreme identifiers (zero is an ordinary
        // one), an add of an identifier already present, a missed find,
        // takes at the head, the tail and the middle with the shift behind
        // them, the unused opcode on a non-empty set, and a take that empties
        // the set.
        offer_word(OP_FIND,   32'h0000_0000);
        offer_word(OP_TAKE,   32'hFFFF_FFFF);
        offer_word(OP_UNUSED, 32'hFFFF_FFFF);
        offer_word(OP_ADD,    32'h0000_0000);
        offer_word(OP_ADD,    32'hFFFF_FFFF);
        offer_word(OP_ADD,    32'h0000_0000);
        offer_word(OP_FIND,   32'hFFFF_FFFF);
        offer_word(OP_FIND,   32'h1234_5678);
        offer_word(OP_ADD,    32'hA5A5_A5A5);
        offer_word(OP_ADD,    32'h5A5A_5A5A);
        offer_word(OP_ADD,    32'h8000_0001);
        offer_word(OP_TAKE,   32'h0000_0000);
        offer_word(OP_FIND,   32'hFFFF_FFFF);
        offer_word(OP_TAKE,   32'h8000_0001);
        offer_word(OP_TAKE,   32'hA5A5_A5A5);
        offer_word(OP_FIND,   32'h5A5A_5A5A);
        offer_word(OP_UNUSED, 32'h5A5A_5A5A);
        offer_word(OP_TAKE,   32'h5A5A_5A5A);
        offer_word(OP_TAKE,   32'hFFFF_FFFF);
        offer_word(OP_TAKE,   32'hFFFF_FFFF);
        offer_word(OP_ADD,    32'h0000_0000);
        offer_word(OP_TAKE,   32'h0000_0000);
        end_burst();
        wait_for_results();

        // Random part. Phases rotate fill, mix, drain, mix. A fill runs the
        // set up to capacity and then knocks on the full set; a drain empties
        // it and then misses three takes or finds; a mix keeps the count wandering
        // with mostly hits on present identifiers and a small pool of values that
        // collide often.
        random_words = 0;
        phase_no     = 0;
        while (random_words < RANDOM_WORDS)
        begin
            case (phase_no % 4)
                0:       kind = PH_FILL;
                2:       kind = PH_DRAIN;
                default: kind = PH_MIX;
            endcase
            // Twice in the run the receiver holds off for a long stretch while
            // the sender keeps offering, so the block backs up to its input.
            if (phase_no == 1 || phase_no == 9)
                hold_requests++;
            steps      = 0;
            tail_left  = 8;
            phase_done = 1'b0;
            while (!phase_done)
            begin
                pick = $urandom_range(0, 99);
                case (kind)
                    PH_FILL:
                    begin
                        if (sb.members.size() >= CAPACITY)
                            tail_left--;
                        if (pick < 80 || sb.members.size() == 0)
                        begin
                            op = OP_ADD;
                            id = $urandom();
                        end
                        else if (pick < 90)
                        begin
                            op = OP_ADD;
                            id = sb.random_member();
                        end
                        else
                        begin
                            op = OP_FIND;
                            id = sb.random_member();
                        end
                        phase_done = (tail_left == 0);
                    end
                    PH_DRAIN:
                    begin
                        if (sb.members.size() == 0)
                            tail_left--;
                        if (sb.members.size() == 0 || pick < 5)
                        begin
                            op = ($urandom_range(0, 1) == 1) ? OP_TAKE : OP_FIND;
                            id = $urandom();
                        end
                        else if (pick < 90)
                        begin
                            op = OP_TAKE;
                            id = sb.random_member();
                        end
                        else
                        begin
                            op = OP_FIND;
                            id = sb.random_member();
                        end
                        phase_done = (tail_left <= 5);
                    end
                    default:
                    begin
                        if (pick < 35)
                            op = OP_FIND;
                        else if (pick < 70)
                            op = OP_ADD;
                        else
                            op = OP_TAKE;
                        pick = $urandom_range(0, 99);
                        if (sb.members.size() != 0 && pick < 60)
                            id = sb.random_member();
                        else if (pick < 75)
                            id = $urandom_range(0, 7);
                        else
                            id = $urandom();
                        phase_done = (steps + 1 >= MIX_WORDS);
                    end
                endcase
                // A few words of noise with the unused opcode.
                if ($urandom_range(0, 99) < 3)
                    op = OP_UNUSED;
                else
                    random_words++;
                offer_word(op, id);
                steps++;
            end
            // After every drain the sender pauses until the block has answered
            // everything it was given.
            if (kind == PH_DRAIN)
            begin
                end_burst();
                wait_for_results();
            end
            phase_no++;
        end

        end_burst();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.owed_words.size() != 0)
        begin
            $error("%0d response words never arrived", sb.owed_words.size());
            sb.mismatches++;
        end
        $display("Checked %0d response words over %0d phases: %0d ok, %0d not found, %0d full.",
                 sb.words_noted, phase_no, sb.ok_words, sb.missed_words, sb.full_words);
        $display("Unused-opcode words: %0d; largest set size reached: %0d of %0d.",
                 sb.unused_words, sb.peak_count, CAPACITY);
        if (sb.mismatches == 0)
            $display("[bounded_id_set] OK");
        else
            $display("[bounded_id_set] ERROR");
        $finish;
    end

endmodule
